### hdl/ldd_pkg.sv
package ldd_pkg;

	// Field widths of the words on the two channels.
	localparam int OP_W     = 2;
	localparam int TID_W    = 16;
	localparam int LID_W    = 32;
	localparam int STATUS_W = 3;
	localparam int HOPS_W   = 5;

	// Table geometry.
	localparam int ENTRIES     = 16;
	localparam int THREAD_BITS = 16;
	localparam int LOCK_BITS   = 32;
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W       = $clog2(ENTRIES + 1);

	typedef logic [OP_W-1:0]        op_t;
	typedef logic [STATUS_W-1:0]    status_t;
	typedef logic [THREAD_BITS-1:0] thread_t;
	typedef logic [LOCK_BITS-1:0]   lock_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	localparam op_t OP_REQUEST = 2'd0;
	localparam op_t OP_ACQUIRE = 2'd1;
	localparam op_t OP_RELEASE = 2'd2;

	localparam status_t STAT_OK        = 3'd0;
	localparam status_t STAT_DEADLOCK  = 3'd1;
	localparam status_t STAT_FULL      = 3'd2;
	localparam status_t STAT_NOT_FOUND = 3'd3;
	localparam status_t STAT_LIMIT     = 3'd4;

	// Microprogram addresses.
	typedef logic [2:0] step_t;
	localparam step_t STEP_IDLE   = 3'd0;
	localparam step_t STEP_INSERT = 3'd1;
	localparam step_t STEP_HOLD   = 3'd2;
	localparam step_t STEP_WAIT   = 3'd3;
	localparam step_t STEP_RECORD = 3'd4;
	localparam step_t STEP_EMIT   = 3'd5;

	typedef enum logic [2:0] {
		A_FETCH,
		A_INSERT,
		A_HOLD,
		A_WAIT,
		A_RECORD,
		A_EMIT
	} act_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NO_REQ,
		C_FULL,
		C_LIMIT,
		C_STOP,
		C_OUT_BUSY
	} cond_t;

	// One control word: datapath action, jump condition and its target,
	// the sequential successor, and whether the operation code picks the successor.
	typedef struct packed {
		act_t  act;
		cond_t cond;
		logic  dispatch;
		step_t jmp;
		step_t seq;
	} ctl_word_t;

	// Status flags returned by the datapath to the sequencer.
	typedef struct packed {
		logic req_taken;
		op_t  op;
		logic full;
		logic limit;
		logic stop;
		logic out_busy;
	} flags_t;

	typedef struct packed {
		logic hit;
		idx_t idx;
	} pick_t;

	function automatic ctl_word_t ucode_rom(input step_t step);
		ctl_word_t w;
		case (step)
			STEP_IDLE:   w = '{A_FETCH,  C_NO_REQ,   1'b1, STEP_IDLE, STEP_IDLE};
			STEP_INSERT: w = '{A_INSERT, C_FULL,     1'b0, STEP_EMIT, STEP_HOLD};
			STEP_HOLD:   w = '{A_HOLD,   C_LIMIT,    1'b0, STEP_EMIT, STEP_WAIT};
			STEP_WAIT:   w = '{A_WAIT,   C_STOP,     1'b0, STEP_EMIT, STEP_HOLD};
			STEP_RECORD: w = '{A_RECORD, C_ALWAYS,   1'b0, STEP_EMIT, STEP_EMIT};
			STEP_EMIT:   w = '{A_EMIT,   C_OUT_BUSY, 1'b0, STEP_EMIT, STEP_IDLE};
			default:     w = '{A_EMIT,   C_ALWAYS,   1'b0, STEP_IDLE, STEP_IDLE};
		endcase
		return w;
	endfunction

	// Lowest set bit of a match vector.
	function automatic pick_t pick_lowest(input logic [ENTRIES-1:0] v);
		pick_t p;
		p.hit = 1'b0;
		p.idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (v[i]) begin
				p.hit = 1'b1;
				p.idx = idx_t'(i);
			end
		end
		return p;
	endfunction

endpackage

### hdl/ldd_if.sv
interface ldd_req_if;
	logic                   valid;
	logic                   ready;
	logic [ldd_pkg::OP_W-1:0]  operation;
	logic [ldd_pkg::TID_W-1:0] thread_id;
	logic [ldd_pkg::LID_W-1:0] lock_id;

	modport source (output valid, operation, thread_id, lock_id, input ready);
	modport sink (input valid, operation, thread_id, lock_id, output ready);
endinterface

interface ldd_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [ldd_pkg::STATUS_W-1:0] status;
	logic [ldd_pkg::TID_W-1:0]    holder_thread;
	logic [ldd_pkg::HOPS_W-1:0]   chain_hops;

	modport source (output valid, status, holder_thread, chain_hops, input ready);
	modport sink (input valid, status, holder_thread, chain_hops, output ready);
endinterface

### hdl/ldd_useq.sv
module ldd_useq (
	input  logic               clk,
	input  logic               arst_n,
	input  ldd_pkg::flags_t    flags,
	output ldd_pkg::ctl_word_t ctl
);
	import ldd_pkg::*;

	step_t step_q;
	step_t step_next;
	logic  cond_true;

	assign ctl = ucode_rom(step_q);

	always_comb begin
		case (ctl.cond)
			C_ALWAYS:   cond_true = 1'b1;
			C_NO_REQ:   cond_true = !flags.req_taken;
			C_FULL:     cond_true = flags.full;
			C_LIMIT:    cond_true = flags.limit;
			C_STOP:     cond_true = flags.stop;
			C_OUT_BUSY: cond_true = flags.out_busy;
			default:    cond_true = 1'b1;
		endcase
	end

	always_comb begin
		if (cond_true) begin
			step_next = ctl.jmp;
		end else if (ctl.dispatch) begin
			case (flags.op)
				OP_REQUEST: step_next = STEP_INSERT;
				OP_ACQUIRE: step_next = STEP_RECORD;
				OP_RELEASE: step_next = STEP_RECORD;
				default:    step_next = STEP_EMIT;
			endcase
		end else begin
			step_next = ctl.seq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

### hdl/lock_wait_deadlock_detector_top.sv
// Lock wait-for deadlock detector. Each word on req is a lock request, acquire or
// release; each produces exactly one word on rsp. Words are taken one at a time:
// acquire and release go through fetch, table lookup and result, and an unused code
// through fetch and result. A request on a full table goes through fetch, insert and
// result. Otherwise a request walks the chain after the insert: for every hop the
// walk loop of the microcode searches the 16-entry table for the lock holder and then
// for the record that holder waits on. The walk stops at a holder on a deadlock or
// because that holder waits on nothing, at a free lock, or at the chain limit of
// ENTRIES holders. The next request is taken while a finished result still waits
// on rsp; a stalled rsp only holds the block in its result step.
module lock_wait_deadlock_detector_top (
	input logic      clk,
	input logic      arst_n,
	ldd_req_if.sink  req,
	ldd_rsp_if.source rsp
);
	import ldd_pkg::*;

	ctl_word_t ctl;
	flags_t    flags;

	logic [ENTRIES-1:0] slot_valid_q;
	logic [ENTRIES-1:0] slot_held_q;
	lock_t              slot_lock_q [ENTRIES];
	thread_t            slot_thread_q [ENTRIES];

	op_t     op_q;
	thread_t th_q;
	lock_t   lk_q;
	lock_t   cur_q;
	thread_t holder_q;
	logic    hhit_q;
	thread_t first_q;
	cnt_t    hops_q;
	status_t status_q;

	logic    rsp_valid_q;
	status_t rsp_status_q;
	thread_t rsp_holder_q;
	cnt_t    rsp_hops_q;

	logic [ENTRIES-1:0] hold_vec;
	logic [ENTRIES-1:0] wait_vec;
	logic [ENTRIES-1:0] rec_vec;
	pick_t free_pk;
	pick_t hold_pk;
	pick_t wait_pk;
	pick_t rec_pk;
	logic  req_taken;
	logic  emit_go;

	ldd_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hold_vec[i] = slot_valid_q[i] && slot_held_q[i] && (slot_lock_q[i] == cur_q);
			wait_vec[i] = slot_valid_q[i] && !slot_held_q[i] && (slot_thread_q[i] == holder_q);
			rec_vec[i]  = slot_valid_q[i] && (slot_lock_q[i] == lk_q) && (slot_thread_q[i] == th_q);
		end
	end

	assign free_pk = pick_lowest(~slot_valid_q);
	assign hold_pk = pick_lowest(hold_vec);
	assign wait_pk = pick_lowest(wait_vec);
	assign rec_pk  = pick_lowest(rec_vec);

	assign req.ready = (ctl.act == A_FETCH);
	assign req_taken = req.valid && req.ready;
	assign emit_go   = (ctl.act == A_EMIT) && !flags.out_busy;

	assign flags.req_taken = req_taken;
	assign flags.op        = req.operation;
	assign flags.full      = !free_pk.hit;
	assign flags.limit     = (hops_q == cnt_t'(ENTRIES));
	// The walk ends when the lock is free, the holder is the requester, or
	// the holder waits on nothing.
	assign flags.stop      = !hhit_q || (holder_q == th_q) || !wait_pk.hit;
	assign flags.out_busy  = rsp_valid_q && !rsp.ready;

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.holder_thread = TID_W'(rsp_holder_q);
	assign rsp.chain_hops    = HOPS_W'(rsp_hops_q);

	// Control state: table occupancy, walk counter, status, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			hops_q       <= '0;
			status_q     <= STAT_OK;
			rsp_valid_q  <= 1'b0;
		end else begin
			// A new result may replace the one leaving in the same cycle.
			if (emit_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (ctl.act)
				A_FETCH: begin
					if (req_taken) begin
						hops_q   <= '0;
						status_q <= STAT_OK;
					end
				end
				A_INSERT: begin
					if (free_pk.hit) begin
						slot_valid_q[free_pk.idx] <= 1'b1;
					end else begin
						status_q <= STAT_FULL;
					end
				end
				A_HOLD: begin
					if (flags.limit) begin
						status_q <= STAT_LIMIT;
					end
				end
				A_WAIT: begin
					if (hhit_q) begin
						hops_q <= hops_q + cnt_t'(1);
						if (holder_q == th_q) begin
							status_q <= STAT_DEADLOCK;
						end
					end
				end
				A_RECORD: begin
					if (!rec_pk.hit) begin
						status_q <= STAT_NOT_FOUND;
					end else if (op_q == OP_RELEASE) begin
						slot_valid_q[rec_pk.idx] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload: table contents, the current word, the walk registers and the result fields.
	always_ff @(posedge clk) begin
		case (ctl.act)
			A_FETCH: begin
				if (req_taken) begin
					op_q    <= req.operation;
					th_q    <= req.thread_id[THREAD_BITS-1:0];
					lk_q    <= req.lock_id[LOCK_BITS-1:0];
					cur_q   <= req.lock_id[LOCK_BITS-1:0];
					first_q <= '0;
				end
			end
			A_INSERT: begin
				if (free_pk.hit) begin
					slot_lock_q[free_pk.idx]   <= lk_q;
					slot_thread_q[free_pk.idx] <= th_q;
					slot_held_q[free_pk.idx]   <= 1'b0;
				end
			end
			A_HOLD: begin
				hhit_q   <= hold_pk.hit;
				holder_q <= slot_thread_q[hold_pk.idx];
			end
			A_WAIT: begin
				if (hhit_q && hops_q == '0) begin
					first_q <= holder_q;
				end
				if (!flags.stop) begin
					cur_q <= slot_lock_q[wait_pk.idx];
				end
			end
			A_RECORD: begin
				if (rec_pk.hit && op_q == OP_ACQUIRE) begin
					slot_held_q[rec_pk.idx] <= 1'b1;
				end
			end
			A_EMIT: begin
				if (emit_go) begin
					rsp_status_q <= status_q;
					rsp_holder_q <= (op_q == OP_REQUEST) ? first_q : '0;
					rsp_hops_q   <= (op_q == OP_REQUEST) ? hops_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_hops_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hops_q <= cnt_t'(ENTRIES))
		else $error("walk counter passed the table depth");

	a_deadlock_hops: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q == STAT_DEADLOCK |-> rsp_hops_q != '0)
		else $error("deadlock reported without any holder on the chain");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q == STAT_FULL |-> rsp_hops_q == '0 && rsp_holder_q == '0)
		else $error("table-full result carries walk data");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_taken |=> !(ctl.act == A_FETCH))
		else $error("accepted word did not start a microprogram run");
`endif

endmodule

### tb/lock_wait_deadlock_detector_checker.sv
module lock_wait_deadlock_detector_checker
	import ldd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ldd_req_if   req,
	ldd_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);

	typedef logic [HOPS_W-1:0] hops_t;

	typedef struct packed {
		status_t status;
		thread_t holder;
		hops_t   hops;
	} lock_verdict_t;

	logic    rec_valid  [ENTRIES];
	lock_t   rec_lock   [ENTRIES];
	thread_t rec_thread [ENTRIES];
	logic    rec_held   [ENTRIES];

	lock_verdict_t verdicts_due[$];
	lock_verdict_t want;

	function automatic int held_slot(input lock_t lk);
		for (int i = 0; i < ENTRIES; i++)
			if (rec_valid[i] && rec_held[i] && rec_lock[i] == lk)
				return i;
		return -1;
	endfunction

	function automatic int waiting_slot(input thread_t th);
		for (int i = 0; i < ENTRIES; i++)
			if (rec_valid[i] && !rec_held[i] && rec_thread[i] == th)
				return i;
		return -1;
	endfunction

	function automatic int claim_slot(input lock_t lk, input thread_t th);
		for (int i = 0; i < ENTRIES; i++)
			if (rec_valid[i] && rec_lock[i] == lk && rec_thread[i] == th)
				return i;
		return -1;
	endfunction

	// Updates the lock table for one word and returns the status word it must produce.
	function automatic lock_verdict_t judge_lock_word(input op_t op, input thread_t th,
			input lock_t lk);
		lock_verdict_t v;
		int            slot;
		int            free_slot;
		int            hops;
		lock_t         cur;
		thread_t       holder;
		logic          done;
		v = '0;
		v.status = STAT_OK;
		case (op)
			OP_REQUEST: begin
				free_slot = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (!rec_valid[i] && free_slot < 0)
						free_slot = i;
				if (free_slot < 0) begin
					v.status = STAT_FULL;
				end else begin
					rec_valid[free_slot]  = 1'b1;
					rec_lock[free_slot]   = lk;
					rec_thread[free_slot] = th;
					rec_held[free_slot]   = 1'b0;
					cur  = lk;
					hops = 0;
					done = 1'b0;
					// Follow lock -> holder -> lock that holder waits on, until it ends.
					while (hops < ENTRIES && !done) begin
						slot = held_slot(cur);
						if (slot < 0) begin
							done = 1'b1;
						end else begin
							holder = rec_thread[slot];
							if (hops == 0)
								v.holder = holder;
							hops++;
							if (holder == th) begin
								v.status = STAT_DEADLOCK;
								done = 1'b1;
							end else begin
								slot = waiting_slot(holder);
								if (slot < 0)
									done = 1'b1;
								else
									cur = rec_lock[slot];
							end
						end
					end
					if (!done)
						v.status = STAT_LIMIT;
					v.hops = hops_t'(hops);
				end
			end
			OP_ACQUIRE: begin
				slot = claim_slot(lk, th);
				if (slot < 0)
					v.status = STAT_NOT_FOUND;
				else
					rec_held[slot] = 1'b1;
			end
			OP_RELEASE: begin
				slot = claim_slot(lk, th);
				if (slot < 0)
					v.status = STAT_NOT_FOUND;
				else
					rec_valid[slot] = 1'b0;
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				rec_valid[i] = 1'b0;
			verdicts_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (verdicts_due.size() == 0) begin
					note_failure($sformatf("unexpected status word: status %0d holder %h hops %0d",
						rsp.status, rsp.holder_thread, rsp.chain_hops));
				end else begin
					want = verdicts_due.pop_front();
					if (rsp.status !== want.status || rsp.holder_thread !== want.holder ||
							rsp.chain_hops !== want.hops)
						note_failure($sformatf(
							"status word mismatch: got status %0d holder %h hops %0d, %s %0d %h %0d",
							rsp.status, rsp.holder_thread, rsp.chain_hops, "want",
							want.status, want.holder, want.hops));
				end
			end
			if (req.valid && req.ready)
				verdicts_due.push_back(judge_lock_word(req.operation, req.thread_id,
					req.lock_id));
			pending = verdicts_due.size();
		end
	end

endmodule

### tb/lock_wait_deadlock_detector_top_tb.sv
module lock_wait_deadlock_detector_top_tb;
	import ldd_pkg::*;

	localparam op_t     OP_UNUSED = 2'd3;
	localparam thread_t T_LOW     = 16'h0001;
	localparam thread_t T_MID     = 16'h5A5A;
	localparam thread_t T_HIGH    = 16'hFFFF;
	localparam lock_t   LOCK_HIGH = 32'hFFFF_FFFF;
	localparam lock_t   LOCK_LOW  = 32'h0000_0001;
	localparam int      POOL      = 5;

	typedef struct {
		lock_t   lk;
		thread_t th;
	} lock_claim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	logic hold_go;
	int   fail_count;
	int   pending;

	thread_t     thread_pool [POOL];
	lock_t       lock_pool   [POOL];
	// Records the table should hold; keeps random acquires and releases meaningful.
	lock_claim_t live_claims[$];

	ldd_req_if req ();
	ldd_rsp_if rsp ();

	lock_wait_deadlock_detector_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	lock_wait_deadlock_detector_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #2 clk = ~clk;

	task automatic send_word(input op_t op, input thread_t th, input lock_t lk);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid     <= 1'b1;
		req.operation <= op;
		req.thread_id <= th;
		req.lock_id   <= lk;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		if (op == OP_REQUEST && live_claims.size() < ENTRIES) begin
			live_claims.push_back('{lk, th});
		end else if (op == OP_RELEASE) begin
			for (int k = 0; k < live_claims.size(); k++) begin
				if (live_claims[k].lk == lk && live_claims[k].th == th) begin
					live_claims.delete(k);
					break;
				end
			end
		end
	endtask

	// Mostly lock traffic over small pools of threads and locks so that chains form,
	// with some noise words carrying arbitrary values.
	task automatic random_word();
		int      r;
		int      req_cut;
		int      pick;
		op_t     op;
		thread_t th;
		lock_t   lk;
		r = $urandom_range(99);
		if (r < 10) begin
			op = op_t'($urandom_range(3));
			th = thread_t'($urandom);
			lk = $urandom;
		end else begin
			r = $urandom_range(99);
			req_cut = (live_claims.size() >= 12) ? 25 : 50;
			if (r < req_cut || live_claims.size() == 0) begin
				op = OP_REQUEST;
				th = thread_pool[$urandom_range(POOL - 1)];
				lk = lock_pool[$urandom_range(POOL - 1)];
			end else begin
				pick = $urandom_range(live_claims.size() - 1);
				th = live_claims[pick].th;
				lk = live_claims[pick].lk;
				op = (r < req_cut + 25) ? OP_ACQUIRE : OP_RELEASE;
			end
		end
		send_word(op, th, lk);
	endtask

	initial begin : rsp_side
		int   hold_left;
		logic hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		rsp.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_go && !hold_used) begin
				hold_left = 300;
				hold_used = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		req.valid     <= 1'b0;
		req.operation <= OP_REQUEST;
		req.thread_id <= '0;
		req.lock_id   <= '0;
		hold_go       <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_UNUSED, T_LOW, LOCK_HIGH);
		send_word(OP_RELEASE, T_LOW, LOCK_HIGH);
		send_word(OP_ACQUIRE, T_MID, LOCK_LOW);
		send_word(OP_REQUEST, T_LOW, LOCK_HIGH);
		send_word(OP_ACQUIRE, T_LOW, LOCK_HIGH);
		send_word(OP_REQUEST, T_MID, LOCK_LOW);
		send_word(OP_ACQUIRE, T_MID, LOCK_LOW);
		send_word(OP_REQUEST, T_LOW, LOCK_LOW);
		// The second thread now closes the cycle between the two locks.
		send_word(OP_REQUEST, T_MID, LOCK_HIGH);
		// A third thread runs into the cycle and never gets back to itself.
		send_word(OP_REQUEST, T_HIGH, LOCK_HIGH);
		send_word(OP_REQUEST, '0, '0);
		send_word(OP_ACQUIRE, '0, '0);
		send_word(OP_REQUEST, T_HIGH, '0);
		send_word(OP_RELEASE, T_HIGH, LOCK_HIGH);
		for (int k = 0; k < 11; k++)
			send_word(OP_REQUEST, T_MID, lock_t'(32'h0000_1000 + k));

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 79; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 79; end
				default: begin idle_pct = 36; stall_pct = 36; end
			endcase
			for (int k = 0; k < POOL; k++) begin
				thread_pool[k] = thread_t'($urandom_range(1, 65535));
				lock_pool[k]   = $urandom;
			end
			for (int n = 0; n < 400; n++) begin
				if (phase == 0 && n == 20)
					hold_go <= 1'b1;
				random_word();
			end
		end
		req.valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("lock_wait_deadlock_detector_top test passed");
		else
			$display("lock_wait_deadlock_detector_top test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("lock_wait_deadlock_detector_top test failed");
		$finish;
	end

endmodule
